// ----- hw/rtl/key_edge_and_autorepeat_macros.svh -----
// assertion macros shared by the key edge and autorepeat rtl
`ifndef KEY_EDGE_AND_AUTOREPEAT_MACROS_SVH
`define KEY_EDGE_AND_AUTOREPEAT_MACROS_SVH

// same-cycle implication, checked out of reset
`define KEA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define KEA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> cons) \
    else $error(msg);

`endif

// ----- hw/rtl/kea_pkg.sv -----
// shared types and constants for the key edge and autorepeat block
`default_nettype none

package kea_pkg;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned KEYIDX_W = 4;
  localparam int unsigned AMOUNT_W = 8;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFGIDX_W = 2;
  localparam int unsigned HOLD_W   = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 2'd0,
    KIND_EVENT = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_e;

  typedef enum logic [CFGIDX_W-1:0] {
    CFG_INITIAL_DELAY   = 2'd0,
    CFG_REPEAT_INTERVAL = 2'd1
  } cfg_idx_e;

  localparam logic [CFG_W-1:0] INITIAL_DELAY_RST   = 16'd30;
  localparam logic [CFG_W-1:0] REPEAT_INTERVAL_RST = 16'd5;

  // per-key timer control
  typedef struct packed {
    logic tick;
    logic clear;
    logic held;
    logic fire_clr;
  } lane_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/kea_timer_lane.sv -----
// one key's saturating hold and repeat timers
`default_nettype none

module kea_timer_lane import kea_pkg::*; #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire lane_ctrl_t             ctrl_i,
  input  wire logic [AMOUNT_W-1:0]    amount_i,
  output logic      [TIMER_WIDTH-1:0] hold_q_o,
  output logic      [TIMER_WIDTH-1:0] hold_d_o,
  output logic      [TIMER_WIDTH-1:0] rpt_q_o
);

  logic [TIMER_WIDTH-1:0] hold_q, hold_d;
  logic [TIMER_WIDTH-1:0] rpt_q, rpt_d;
  logic [TIMER_WIDTH:0]   hold_sum, rpt_sum;
  logic [TIMER_WIDTH-1:0] hold_sat, rpt_sat;

  always_comb begin
    hold_sum = {1'b0, hold_q} + (TIMER_WIDTH+1)'(amount_i);
    rpt_sum  = {1'b0, rpt_q} + (TIMER_WIDTH+1)'(amount_i);
    hold_sat = hold_sum[TIMER_WIDTH] ? '1 : hold_sum[TIMER_WIDTH-1:0];
    rpt_sat  = rpt_sum[TIMER_WIDTH] ? '1 : rpt_sum[TIMER_WIDTH-1:0];
  end

  always_comb begin
    hold_d = hold_q;
    rpt_d  = rpt_q;
    priority if (ctrl_i.clear) begin
      hold_d = '0;
      rpt_d  = '0;
    end else if (ctrl_i.tick) begin
      // released keys drop both timers
      hold_d = ctrl_i.held ? hold_sat : '0;
      rpt_d  = ctrl_i.held ? rpt_sat : '0;
    end else if (ctrl_i.fire_clr) begin
      rpt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= '0;
      rpt_q  <= '0;
    end else begin
      hold_q <= hold_d;
      rpt_q  <= rpt_d;
    end
  end

  assign hold_q_o = hold_q;
  assign hold_d_o = hold_d;
  assign rpt_q_o  = rpt_q;

endmodule

`default_nettype wire

// ----- hw/rtl/key_edge_and_autorepeat.sv -----
// key edge detector with typematic autorepeat, top level
//
//   channel  | handshake         | fields
//   ---------+-------------------+--------------------------------------------------
//   command  | start, busy       | kind_i, key_index_i, key_down_i, tick_amount_i
//   result   | done_o strobe     | is_down_o, was_pressed_o, was_released_o,
//            |                   | repeat_fire_o, hold_time_o
//   config   | cfg_we_i          | cfg_idx_i, cfg_wdata_i
//
// one command per cycle; busy stays low, so a command may follow in every cycle.
// the command passes the input register, then the key state update and the result register,
// whose done_o strobe marks the result beat.
// key bits and timers update in the result stage, so commands apply in order.
// reset clears key bits and timers and loads the register defaults.
`default_nettype none
`include "key_edge_and_autorepeat_macros.svh"

module key_edge_and_autorepeat import kea_pkg::*; #(
  parameter int unsigned NUM_KEYS    = 16,
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [KIND_W-1:0]   kind_i,
  input  wire logic [KEYIDX_W-1:0] key_index_i,
  input  wire logic                key_down_i,
  input  wire logic [AMOUNT_W-1:0] tick_amount_i,
  input  wire logic                cfg_we_i,
  input  wire logic [CFGIDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]    cfg_wdata_i,
  output logic                     done_o,
  output logic                     is_down_o,
  output logic                     was_pressed_o,
  output logic                     was_released_o,
  output logic                     repeat_fire_o,
  output logic [HOLD_W-1:0]        hold_time_o
);

  localparam int unsigned KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int unsigned CMP_W = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;

  // configuration
  logic [CFG_W-1:0] init_dly_q, rpt_ivl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_dly_q <= INITIAL_DELAY_RST;
      rpt_ivl_q  <= REPEAT_INTERVAL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_INITIAL_DELAY:   init_dly_q <= cfg_wdata_i;
        CFG_REPEAT_INTERVAL: rpt_ivl_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input register
  logic                in_vld_q;
  kind_e               kind_q;
  logic [KEYIDX_W-1:0] key_q;
  logic                level_q;
  logic [AMOUNT_W-1:0] amount_q;
  logic                accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q   <= kind_e'(kind_i);
      key_q    <= key_index_i;
      level_q  <= key_down_i;
      amount_q <= tick_amount_i;
    end
  end

  // key state and timer lanes
  logic [NUM_KEYS-1:0]    cur_q, cur_d, prev_q, prev_d, key_bit;
  logic [KEY_W-1:0]       key_sel;
  logic                   key_ok;
  logic                   tick_en, clear_en, query_en, fire;
  logic [TIMER_WIDTH-1:0] hold_q_w [NUM_KEYS];
  logic [TIMER_WIDTH-1:0] hold_d_w [NUM_KEYS];
  logic [TIMER_WIDTH-1:0] rpt_q_w  [NUM_KEYS];
  lane_ctrl_t             lane_ctrl [NUM_KEYS];

  assign key_sel = KEY_W'(key_q);
  assign key_ok  = 32'(key_q) < NUM_KEYS;
  assign key_bit = key_ok ? (NUM_KEYS'(1) << key_sel) : '0;

  for (genvar i = 0; i < NUM_KEYS; i++) begin : g_lane
    assign lane_ctrl[i] = '{
      tick:     tick_en,
      clear:    clear_en,
      held:     cur_q[i],
      fire_clr: fire && (key_sel == KEY_W'(i))
    };

    kea_timer_lane #(
      .TIMER_WIDTH(TIMER_WIDTH)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (lane_ctrl[i]),
      .amount_i (amount_q),
      .hold_q_o (hold_q_w[i]),
      .hold_d_o (hold_d_w[i]),
      .rpt_q_o  (rpt_q_w[i])
    );
  end

  logic                   down_now, prev_now, pressed, released, repeat_due;
  logic [TIMER_WIDTH-1:0] hold_cur, rpt_cur, hold_new;
  logic [CMP_W-1:0]       hold_ext;
  logic [HOLD_W-1:0]      hold_out;

  always_comb begin
    cur_d    = cur_q;
    prev_d   = prev_q;
    tick_en  = 1'b0;
    clear_en = 1'b0;
    query_en = 1'b0;
    if (in_vld_q) begin
      unique case (kind_q)
        KIND_TICK: begin
          prev_d  = cur_q;
          tick_en = 1'b1;
        end
        KIND_EVENT: begin
          cur_d = level_q ? (cur_q | key_bit) : (cur_q & ~key_bit);
        end
        KIND_QUERY: begin
          query_en = 1'b1;
        end
        KIND_CLEAR: begin
          cur_d    = '0;
          prev_d   = '0;
          clear_en = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    hold_cur = key_ok ? hold_q_w[key_sel] : '0;
    rpt_cur  = key_ok ? rpt_q_w[key_sel] : '0;
    hold_new = key_ok ? hold_d_w[key_sel] : '0;
    down_now = key_ok && cur_d[key_sel];
    prev_now = key_ok && prev_d[key_sel];
    pressed  = down_now && !prev_now;
    released = !down_now && prev_now;
    // query sees the pre-update timers; a firing query clears that key's repeat timer
    repeat_due = down_now
              && (CMP_W'(hold_cur) >= CMP_W'(init_dly_q))
              && (CMP_W'(rpt_cur) >= CMP_W'(rpt_ivl_q));
    fire     = query_en && key_ok && (pressed || repeat_due);
    hold_ext = CMP_W'(hold_new);
    hold_out = (hold_ext > CMP_W'({HOLD_W{1'b1}})) ? '1 : hold_ext[HOLD_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= '0;
      prev_q <= '0;
      done_o <= 1'b0;
    end else begin
      cur_q  <= cur_d;
      prev_q <= prev_d;
      done_o <= in_vld_q;
    end
  end

  // result beat payload
  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      is_down_o      <= down_now;
      was_pressed_o  <= pressed;
      was_released_o <= released;
      repeat_fire_o  <= fire;
      hold_time_o    <= hold_out;
    end
  end

  `KEA_ASSERT_NEXT(a_result_latency, accept, ##1 done_o, "result beat missing after command")
  `KEA_ASSERT_NOW(a_fire_needs_down, done_o && repeat_fire_o, is_down_o, "fire on released key")
  `KEA_ASSERT_NOW(a_edges_exclusive, done_o, !(was_pressed_o && was_released_o), "both edges")
  `KEA_ASSERT_NOW(a_fire_one_key, 1'b1, $onehot0(fire ? key_bit : '0), "fire on several keys")

endmodule

`default_nettype wire
